// ===== design/tsbs_pkg.sv =====
package tsbs_pkg;

   // operation codes of an input item
   localparam logic [1:0] OP_TICK       = 2'd0;
   localparam logic [1:0] OP_NORMAL_REQ = 2'd1;
   localparam logic [1:0] OP_MIXED_REQ  = 2'd2;

   // configuration register indexes
   localparam int CSR_INDEX_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NORMAL_PERIOD = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NORMAL_REPEATS = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FIRST_PERIOD = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FIRST_REPEATS = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SECOND_PERIOD = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SECOND_REPEATS = 3'd5;

   localparam int CSR_DATA_WIDTH = 16;
   localparam int TICKS_WIDTH    = 12;

   // reset values of the registers
   localparam logic [15:0] NORMAL_PERIOD_RESET  = 16'd500;
   localparam logic [15:0] NORMAL_REPEATS_RESET = 16'd5;
   localparam logic [15:0] FIRST_PERIOD_RESET   = 16'd500;
   localparam logic [15:0] FIRST_REPEATS_RESET  = 16'd3;
   localparam logic [15:0] SECOND_PERIOD_RESET  = 16'd200;
   localparam logic [15:0] SECOND_REPEATS_RESET = 16'd2;

   // reciprocal of 5 scaled by 2^18, exact for 14-bit operands
   localparam logic [15:0] RECIP_FIVE = 16'hCCCD;

   typedef struct packed {
      logic [1:0] op;
      logic       flag_value;
   } req_payload_type;

   typedef struct packed {
      logic led_lit;
      logic running;
      logic mixed_running;
      logic in_second_stage;
      logic normal_request;
      logic mixed_request;
   } rsp_payload_type;

   // settings as the sequencer uses them: periods already as half-period ticks
   typedef struct packed {
      logic [TICKS_WIDTH-1:0] normal_half;
      logic [15:0]            normal_repeats;
      logic [TICKS_WIDTH-1:0] first_half;
      logic [15:0]            first_repeats;
      logic [TICKS_WIDTH-1:0] second_half;
      logic [15:0]            second_repeats;
   } cfg_type;

   // half period in 10 ms ticks: (ms / 10) >> 1 == (ms >> 2) / 5, at least 1
   function automatic logic [TICKS_WIDTH-1:0] half_ticks(input logic [15:0] ms);
      logic [29:0]            prod;
      logic [TICKS_WIDTH-1:0] t;
      prod = 30'(ms[15:2]) * 30'(RECIP_FIVE);
      t = prod[29:18];
      return (t == '0) ? TICKS_WIDTH'(1) : t;
   endfunction

endpackage

// ===== design/tsbs_chan_if.sv =====
interface tsbs_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== design/tsbs_csr.sv =====
module tsbs_csr
   import tsbs_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   output cfg_type                    cfg
);

   cfg_type                cfg_ff;
   cfg_type                cfg_in;
   logic [TICKS_WIDTH-1:0] wdata_half;

   // period registers keep the converted half period
   assign wdata_half = half_ticks(csr_wdata);

   // register write decode, unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_NORMAL_PERIOD:  cfg_in.normal_half    = wdata_half;
            CSR_NORMAL_REPEATS: cfg_in.normal_repeats = csr_wdata;
            CSR_FIRST_PERIOD:   cfg_in.first_half     = wdata_half;
            CSR_FIRST_REPEATS:  cfg_in.first_repeats  = csr_wdata;
            CSR_SECOND_PERIOD:  cfg_in.second_half    = wdata_half;
            CSR_SECOND_REPEATS: cfg_in.second_repeats = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.normal_half    <= half_ticks(NORMAL_PERIOD_RESET);
         cfg_ff.normal_repeats <= NORMAL_REPEATS_RESET;
         cfg_ff.first_half     <= half_ticks(FIRST_PERIOD_RESET);
         cfg_ff.first_repeats  <= FIRST_REPEATS_RESET;
         cfg_ff.second_half    <= half_ticks(SECOND_PERIOD_RESET);
         cfg_ff.second_repeats <= SECOND_REPEATS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== design/tsbs_core.sv =====
module tsbs_core
   import tsbs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   tsbs_chan_if.sink   req,
   tsbs_chan_if.source rsp
);

   typedef struct packed {
      logic                   normal_req;
      logic                   mixed_req;
      logic                   active;
      logic                   lit;
      logic                   mode_mixed;
      logic                   stage_second;
      logic [TICKS_WIDTH-1:0] countdown;
      logic [TICKS_WIDTH-1:0] reload;
      logic [TICKS_WIDTH-1:0] second_reload;
      logic [15:0]            normal_left;
      logic [15:0]            first_left;
      logic [15:0]            second_left;
   } seq_state_type;

   logic            in_valid_ff;
   logic            in_valid_in;
   req_payload_type in_item_ff;
   req_payload_type in_item_in;
   logic            out_valid_ff;
   logic            out_valid_in;
   rsp_payload_type out_item_ff;
   rsp_payload_type out_item_in;
   seq_state_type   st_ff;
   seq_state_type   st_in;
   logic            advance;
   logic            stop;

   // the held item moves on when the result register is free or being drained
   assign advance   = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;

   // sequencer update for the held item
   always_comb begin
      st_in = st_ff;
      stop  = (!st_ff.mode_mixed && !st_ff.normal_req) ||
              (st_ff.mode_mixed && !st_ff.mixed_req);

      unique case (in_item_ff.op)
         OP_TICK: begin
            if (st_ff.active) begin
               if (stop) begin
                  st_in.active = 1'b0;
               end else begin
                  st_in.countdown = st_ff.countdown - TICKS_WIDTH'(1);
                  if (st_in.countdown == '0) begin
                     st_in.countdown = st_ff.reload;
                     if (!st_ff.lit) begin
                        st_in.lit = 1'b1;
                     end else begin
                        st_in.lit = 1'b0;
                        if (!st_ff.mode_mixed) begin
                           // zero count means endless
                           if (st_ff.normal_left != '0) begin
                              st_in.normal_left = st_ff.normal_left - 16'd1;
                              if (st_in.normal_left == '0) begin
                                 st_in.active     = 1'b0;
                                 st_in.normal_req = 1'b0;
                              end
                           end
                        end else if (!st_ff.stage_second) begin
                           st_in.first_left = st_ff.first_left - 16'd1;
                           if (st_in.first_left == '0) begin
                              st_in.stage_second = 1'b1;
                              st_in.reload       = st_ff.second_reload;
                              st_in.countdown    = st_ff.second_reload;
                           end
                        end else begin
                           st_in.second_left = st_ff.second_left - 16'd1;
                           if (st_in.second_left == '0) begin
                              st_in.active    = 1'b0;
                              st_in.mixed_req = 1'b0;
                           end
                        end
                     end
                  end
               end
            end
         end
         OP_NORMAL_REQ: st_in.normal_req = in_item_ff.flag_value;
         OP_MIXED_REQ: begin
            st_in.mixed_req = in_item_ff.flag_value;
            if (in_item_ff.flag_value) begin
               st_in.normal_req = 1'b0;
            end
         end
         default: st_in = st_ff;
      endcase

      // dispatch: mixed request wins over normal
      if (st_in.mixed_req) begin
         if (!st_in.active || !st_in.mode_mixed) begin
            st_in.normal_req    = 1'b0;
            st_in.reload        = cfg.first_half;
            st_in.second_reload = cfg.second_half;
            st_in.countdown     = cfg.first_half;
            st_in.mode_mixed    = 1'b1;
            st_in.stage_second  = 1'b0;
            st_in.first_left    = cfg.first_repeats;
            st_in.second_left   = cfg.second_repeats;
            st_in.lit           = 1'b1;
            st_in.active        = 1'b1;
         end
      end else if (st_in.normal_req && !st_in.active) begin
         st_in.reload      = cfg.normal_half;
         st_in.countdown   = cfg.normal_half;
         st_in.normal_left = cfg.normal_repeats;
         st_in.mode_mixed  = 1'b0;
         st_in.lit         = 1'b1;
         st_in.active      = 1'b1;
      end

      out_item_in.led_lit         = st_in.lit && st_in.active;
      out_item_in.running         = st_in.active;
      out_item_in.mixed_running   = st_in.mode_mixed;
      out_item_in.in_second_stage = st_in.mode_mixed && st_in.stage_second;
      out_item_in.normal_request  = st_in.normal_req;
      out_item_in.mixed_request   = st_in.mixed_req;
   end

   // input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req.valid && req.ready) begin
         in_valid_in = 1'b1;
         in_item_in  = req.payload;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // result register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         st_ff        <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            st_ff <= st_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      if (advance) begin
         out_item_ff <= out_item_in;
      end
   end

   assign rsp.valid   = out_valid_ff;
   assign rsp.payload = out_item_ff;

endmodule

// ===== design/two_speed_led_blink_sequencer_unit.sv =====
// LED blink sequencer with a normal and a mixed two-speed mode. Each request
// transaction is a 10 ms tick or a write of one of the two request flags and
// produces exactly one response transaction with the LED and mode status. A
// transaction is taken every cycle when the response side keeps up; the
// response is registered: the input register holds the transaction, then
// one state update writes it into the result register, and that single
// update stage sets the rate of one transaction per cycle. Period registers
// are converted to half-period ticks when written; all register values take
// effect at the next animation start.
module two_speed_led_blink_sequencer_unit
   import tsbs_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   tsbs_chan_if.sink                  req,
   tsbs_chan_if.source                rsp,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   cfg_type cfg;

   // configuration registers
   tsbs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // sequencer with input and result registers
   tsbs_core u_core (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .req   (req),
      .rsp   (rsp)
   );

endmodule
